### rtl/tmp_pkg.sv
// ----------------------------------------------------------------------------
// tmp_pkg
// Shared types and constants of the trapezoidal motion profile evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package tmp_pkg;

   // Register map, by register index (byte address is four times the index).
   localparam logic [1:0] REG_HEIGHT   = 2'd0;
   localparam logic [1:0] REG_DURATION = 2'd1;
   localparam logic [1:0] REG_ACC_END  = 2'd2;
   localparam logic [1:0] REG_DEC_BEG  = 2'd3;

   localparam logic [31:0] HEIGHT_RESET   = 32'd65536;
   localparam logic [30:0] DURATION_RESET = 31'd65536;
   localparam logic [15:0] ACC_END_RESET  = 16'd16384;
   localparam logic [15:0] DEC_BEG_RESET  = 16'd49152;

   // Coefficient magnitudes saturate at 2^47-1, products at 2^62.
   localparam logic [46:0] COEF_CAP = {47{1'b1}};
   localparam logic [62:0] PROD_CAP = {1'b1, 62'b0};

   // Derived quantities handed from the coefficient sequencer to the datapath.
   typedef struct packed {
      logic [30:0] ev;     // end of acceleration phase, Q16.16
      logic [30:0] ew;     // start of deceleration phase, Q16.16
      logic [46:0] a;      // |A|, Q24.24
      logic [46:0] b;      // |B|, Q24.24
      logic [62:0] p;      // floor(|A|*ev / 2^8), capped
      logic [62:0] v2;     // plateau velocity floor(|A|*ev / 2^24)
      logic        bad;    // invalid segment configuration
      logic        busy;   // coefficients being recomputed
   } coef_type;

endpackage

`default_nettype wire

### rtl/tmp_coef_unit.sv
// ----------------------------------------------------------------------------
// tmp_coef_unit
// Sequencer that derives the segment times and the coefficients A and B from
// the configuration registers, using two serial restoring dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module tmp_coef_unit
   import tmp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] height,
   input  wire logic [30:0] duration,
   input  wire logic [15:0] acc_end,
   input  wire logic [15:0] dec_beg,
   output coef_type         coef
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SEG   = 3'd1;
   localparam logic [2:0] ST_DIFF  = 3'd2;
   localparam logic [2:0] ST_PROD  = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_SCALE = 3'd5;
   localparam logic [2:0] ST_FINAL = 3'd6;

   localparam logic [6:0] DIV_LAST = 7'd72;

   logic [2:0]  state_ff, state_in;
   logic [6:0]  cnt_ff;
   logic [30:0] ev_ff, ew_ff;
   logic        bad_ff;
   logic [31:0] dsum_ff;
   logic [30:0] dtail_ff;
   logic [62:0] ma_ff, mb_ff;
   logic [31:0] num_ff;
   logic [62:0] rema_ff, remb_ff;
   logic [46:0] qa_ff, qb_ff;
   logic        sata_ff, satb_ff;
   logic [46:0] a_ff, b_ff;
   logic [53:0] ph_ff;
   logic [54:0] pl_ff;
   logic [62:0] p_ff, v2_ff;

   logic [46:0] pev, pew;
   logic [30:0] ev_c, ew_c;
   logic        div_bit;
   logic [63:0] rema_sh, remb_sh;
   logic        gea, geb;
   logic [47:0] qa_sh, qb_sh;
   logic [46:0] a_fin, b_fin;
   logic [77:0] pfull;

   always_comb begin
      pev     = {31'b0, acc_end} * {16'b0, duration};
      pew     = {31'b0, dec_beg} * {16'b0, duration};
      ev_c    = pev[46:16];
      ew_c    = pew[46:16];
      div_bit = num_ff[31];
      rema_sh = {rema_ff, div_bit};
      remb_sh = {remb_ff, div_bit};
      gea     = rema_sh >= {1'b0, ma_ff};
      geb     = remb_sh >= {1'b0, mb_ff};
      qa_sh   = {qa_ff, gea};
      qb_sh   = {qb_ff, geb};
      a_fin   = sata_ff ? COEF_CAP : qa_ff;
      b_fin   = satb_ff ? COEF_CAP : qb_ff;
      pfull   = {ph_ff, 24'b0} + {23'b0, pl_ff};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  state_in = ST_IDLE;
         ST_SEG:   state_in = ((duration == 31'd0) || (ev_c == 31'd0) || (acc_end > dec_beg))
                              ? ST_IDLE : ST_DIFF;
         ST_DIFF:  state_in = ST_PROD;
         ST_PROD:  state_in = ST_DIV;
         ST_DIV:   state_in = (cnt_ff == 7'd0) ? ST_SCALE : ST_DIV;
         ST_SCALE: state_in = ST_FINAL;
         ST_FINAL: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
      if (start) begin
         state_in = ST_SEG;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SEG;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_SEG: begin
            ev_ff  <= ev_c;
            ew_ff  <= ew_c;
            bad_ff <= (duration == 31'd0) || (ev_c == 31'd0) || (acc_end > dec_beg);
         end
         ST_DIFF: begin
            dsum_ff  <= {1'b0, duration} - {1'b0, ev_ff} + {1'b0, ew_ff};
            dtail_ff <= duration - ew_ff;
         end
         ST_PROD: begin
            ma_ff   <= {32'b0, ev_ff} * {31'b0, dsum_ff};
            mb_ff   <= {32'b0, dtail_ff} * {31'b0, dsum_ff};
            num_ff  <= height[31] ? (32'd0 - height) : height;
            rema_ff <= '0;
            remb_ff <= '0;
            qa_ff   <= '0;
            qb_ff   <= '0;
            sata_ff <= 1'b0;
            satb_ff <= 1'b0;
            cnt_ff  <= DIV_LAST;
         end
         ST_DIV: begin
            // One quotient bit of each division per cycle, dividend MSB first.
            num_ff  <= {num_ff[30:0], 1'b0};
            rema_ff <= gea ? 63'(rema_sh - {1'b0, ma_ff}) : rema_sh[62:0];
            remb_ff <= geb ? 63'(remb_sh - {1'b0, mb_ff}) : remb_sh[62:0];
            sata_ff <= sata_ff | qa_sh[47];
            satb_ff <= satb_ff | qb_sh[47];
            qa_ff   <= sata_ff ? qa_ff : qa_sh[46:0];
            qb_ff   <= satb_ff ? qb_ff : qb_sh[46:0];
            cnt_ff  <= cnt_ff - 7'd1;
         end
         ST_SCALE: begin
            a_ff  <= a_fin;
            b_ff  <= b_fin;
            ph_ff <= {31'b0, a_fin[46:24]} * {23'b0, ev_ff};
            pl_ff <= {31'b0, a_fin[23:0]} * {24'b0, ev_ff};
         end
         ST_FINAL: begin
            p_ff  <= (|pfull[77:71] || (pfull[70] && |pfull[69:8])) ? PROD_CAP : pfull[70:8];
            v2_ff <= {9'b0, pfull[77:24]};
         end
         default: begin
            cnt_ff <= cnt_ff;
         end
      endcase
   end

   assign coef.ev   = ev_ff;
   assign coef.ew   = ew_ff;
   assign coef.a    = a_ff;
   assign coef.b    = b_ff;
   assign coef.p    = p_ff;
   assign coef.v2   = v2_ff;
   assign coef.bad  = bad_ff;
   assign coef.busy = (state_ff != ST_IDLE);

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff <= DIV_LAST))
      else $error("divider step count out of range");

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROD) && !start |=> (state_ff == ST_DIV) && (cnt_ff == DIV_LAST))
      else $error("divider did not start with a full step count");

   a_valid_ev: assert property (@(posedge clock) disable iff (reset)
      $fell(coef.busy) && !bad_ff |-> (ev_ff != 31'd0))
      else $error("valid configuration finished with zero acceleration time");

endmodule

`default_nettype wire

### rtl/trapezoid_motion_profile.sv
// ----------------------------------------------------------------------------
// trapezoid_motion_profile
// Evaluates a constant-acceleration (trapezoidal velocity) move at one time
// sample per item: position, velocity and acceleration in Q16.16.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  req_*     in         tdata[31:0] time_sample
//  rsp_*     out        tdata position/velocity/acceleration, tuser config_error
//  csr_*     in/out     APB registers: height, duration, accel end, decel start
//
//  An item passes six register stages, the last of which drives rsp_tvalid, and
//  a new item can be accepted in every cycle while the coefficient sequencer is
//  idle and the output does not stall. After reset, and after each register
//  write, the coefficient sequencer runs, using its two serial dividers; req_tready
//  is low meanwhile. Reset is synchronous and active high.
//  Each stage advances when it is empty or the stage after it advances, so a
//  stalled output holds its item and the earlier stages keep filling.
// ----------------------------------------------------------------------------
`default_nettype none

module trapezoid_motion_profile
   import tmp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Input items.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] time_sample
   // Result items.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [95:0]      rsp_tdata,   // [31:0] position, [63:32] velocity,
                                         // [95:64] acceleration
   output logic             rsp_tuser,   // [0] config_error
   // Configuration.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // Per-item decode of which segment of the profile the sample falls in.
   typedef struct packed {
      logic bad;      // configuration invalid: all zeros
      logic nonpos;   // sample at or before zero
      logic past;     // sample at or after the end of the move
      logic rgn1;     // sample within the acceleration phase
      logic decel;    // sample within the deceleration phase
   } flag_type;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [31:0] height_ff;
   logic [30:0] duration_ff;
   logic [15:0] acc_end_ff;
   logic [15:0] dec_beg_ff;
   logic        wr_en;
   coef_type    coef;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff   <= HEIGHT_RESET;
         duration_ff <= DURATION_RESET;
         acc_end_ff  <= ACC_END_RESET;
         dec_beg_ff  <= DEC_BEG_RESET;
      end else if (wr_en) begin
         unique case (csr_paddr[3:2])
            REG_HEIGHT:   height_ff   <= csr_pwdata;
            REG_DURATION: duration_ff <= csr_pwdata[30:0];
            REG_ACC_END:  acc_end_ff  <= csr_pwdata[15:0];
            REG_DEC_BEG:  dec_beg_ff  <= csr_pwdata[15:0];
            default:      height_ff   <= height_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_HEIGHT:   csr_prdata = height_ff;
         REG_DURATION: csr_prdata = {1'b0, duration_ff};
         REG_ACC_END:  csr_prdata = {16'b0, acc_end_ff};
         REG_DEC_BEG:  csr_prdata = {16'b0, dec_beg_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // Every write restarts the coefficient computation from the new values.
   tmp_coef_unit u_coef (
      .clock    (clock),
      .reset    (reset),
      .start    (wr_en && !reset),
      .height   (height_ff),
      .duration (duration_ff),
      .acc_end  (acc_end_ff),
      .dec_beg  (dec_beg_ff),
      .coef     (coef)
   );

   // ---------------------------------------------------------------------
   // Helpers for the split 64x64 products
   // ---------------------------------------------------------------------

   // Four 32x32 partial products of x*y.
   function automatic logic [3:0][63:0] part_mul(input logic [63:0] x, input logic [63:0] y);
      logic [3:0][63:0] r;
      r[0] = {32'b0, x[31:0]}  * {32'b0, y[31:0]};
      r[1] = {32'b0, x[31:0]}  * {32'b0, y[63:32]};
      r[2] = {32'b0, x[63:32]} * {32'b0, y[31:0]};
      r[3] = {32'b0, x[63:32]} * {32'b0, y[63:32]};
      return r;
   endfunction

   function automatic logic [127:0] part_sum(input logic [3:0][63:0] p);
      return {64'b0, p[0]} + {32'b0, p[1], 32'b0} + {32'b0, p[2], 32'b0} + {p[3], 64'b0};
   endfunction

   // Caps an already shifted product at 2^62.
   function automatic logic [62:0] cap62(input logic [127:0] v);
      if (|v[127:63] || (v[62] && |v[61:0])) begin
         return PROD_CAP;
      end
      return v[62:0];
   endfunction

   function automatic logic [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return 32'h7fff_ffff;
      end
      if (v < -66'sd2147483648) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   // ---------------------------------------------------------------------
   // Pipeline handshake: a stage loads when it is empty or its item moves on.
   // ---------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic en1, en2, en3, en4, en5, en6;

   assign en6        = !v6_ff || rsp_tready;
   assign en5        = !v5_ff || en6;
   assign en4        = !v4_ff || en5;
   assign en3        = !v3_ff || en4;
   assign en2        = !v2_ff || en3;
   assign en1        = !v1_ff || en2;
   assign req_tready = en1 && !coef.busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_tvalid && req_tready;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
         if (en5) begin
            v5_ff <= v4_ff;
         end
         if (en6) begin
            v6_ff <= v5_ff;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: sample register.
   // ---------------------------------------------------------------------
   logic [31:0] x1_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         x1_ff <= req_tdata;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: segment decode, squares of the elapsed times.
   // ---------------------------------------------------------------------
   logic [30:0] u_c, d_c;
   flag_type    flg_c, flg2_ff;
   logic [61:0] uu2_ff, dd2_ff;
   logic [30:0] u2_ff, d2_ff;
   logic [31:0] t2_ff;

   always_comb begin
      u_c          = x1_ff[30:0];
      d_c          = u_c - coef.ew;
      flg_c.bad    = coef.bad;
      flg_c.nonpos = x1_ff[31] || (x1_ff == 32'd0);
      flg_c.past   = (u_c >= duration_ff);
      flg_c.rgn1   = (u_c < coef.ev);
      flg_c.decel  = (u_c > coef.ew);
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         flg2_ff <= flg_c;
         u2_ff   <= u_c;
         d2_ff   <= d_c;
         uu2_ff  <= {31'b0, u_c} * {31'b0, u_c};
         dd2_ff  <= {31'b0, d_c} * {31'b0, d_c};
         // Cruise position factor 2u - ev, meaningful once u >= ev.
         t2_ff   <= {u_c, 1'b0} - {1'b0, coef.ev};
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: partial products. The acceleration-side position term uses
   // |A|*u^2 in the first phase and the plateau factor times (2u-ev) after it.
   // ---------------------------------------------------------------------
   logic [3:0][63:0] pa3_ff, pb3_ff, va3_ff, vb3_ff;
   flag_type         flg3_ff;
   logic [63:0]      pax, pay;

   always_comb begin
      pax = flg2_ff.rgn1 ? {17'b0, coef.a} : {1'b0, coef.p};
      pay = flg2_ff.rgn1 ? {2'b0, uu2_ff} : {32'b0, t2_ff};
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         flg3_ff <= flg2_ff;
         pa3_ff  <= part_mul(pax, pay);
         pb3_ff  <= part_mul({17'b0, coef.b}, {2'b0, dd2_ff});
         va3_ff  <= part_mul({17'b0, coef.a}, {33'b0, u2_ff});
         vb3_ff  <= part_mul({17'b0, coef.b}, {33'b0, d2_ff});
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: full products.
   // ---------------------------------------------------------------------
   logic [127:0] pa4_ff, pb4_ff, va4_ff, vb4_ff;
   flag_type     flg4_ff;

   always_ff @(posedge clock) begin
      if (en4) begin
         flg4_ff <= flg3_ff;
         pa4_ff  <= part_sum(pa3_ff);
         pb4_ff  <= part_sum(pb3_ff);
         va4_ff  <= part_sum(va3_ff);
         vb4_ff  <= part_sum(vb3_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: scale back to Q16.16 and cap each term.
   // ---------------------------------------------------------------------
   logic [62:0] ta5_ff, tb5_ff, va5_ff, vb5_ff;
   flag_type    flg5_ff;

   always_ff @(posedge clock) begin
      if (en5) begin
         flg5_ff <= flg4_ff;
         ta5_ff  <= cap62(flg4_ff.rgn1 ? (pa4_ff >> 41) : (pa4_ff >> 33));
         tb5_ff  <= cap62(pb4_ff >> 41);
         va5_ff  <= cap62(va4_ff >> 24);
         vb5_ff  <= cap62(vb4_ff >> 24);
      end
   end

   // ---------------------------------------------------------------------
   // Stage 6: combine the phases, apply the sign of h, saturate.
   // ---------------------------------------------------------------------
   logic signed [65:0] pos_c, vel_c, acc_c;
   logic [31:0]        pos_o, vel_o, acc_o;
   logic [31:0]        pos6_ff, vel6_ff, acc6_ff;
   logic               err6_ff;

   always_comb begin
      if (flg5_ff.rgn1) begin
         pos_c = $signed({3'b0, ta5_ff});
         vel_c = $signed({3'b0, va5_ff});
         acc_c = $signed({27'b0, coef.a[46:8]});
      end else begin
         pos_c = $signed({3'b0, ta5_ff});
         vel_c = $signed({3'b0, coef.v2});
         acc_c = '0;
         if (flg5_ff.decel) begin
            pos_c = pos_c - $signed({3'b0, tb5_ff});
            vel_c = vel_c - $signed({3'b0, vb5_ff});
            acc_c = -$signed({27'b0, coef.b[46:8]});
         end
      end
      if (height_ff[31]) begin
         pos_c = -pos_c;
         vel_c = -vel_c;
         acc_c = -acc_c;
      end
      pos_o = sat32(pos_c);
      vel_o = sat32(vel_c);
      acc_o = sat32(acc_c);
      if (flg5_ff.bad || flg5_ff.nonpos) begin
         pos_o = '0;
         vel_o = '0;
         acc_o = '0;
      end else if (flg5_ff.past) begin
         pos_o = height_ff;
         vel_o = '0;
         acc_o = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en6) begin
         pos6_ff <= pos_o;
         vel6_ff <= vel_o;
         acc6_ff <= acc_o;
         err6_ff <= flg5_ff.bad;
      end
   end

   assign rsp_tvalid = v6_ff;
   assign rsp_tdata  = {acc6_ff, vel6_ff, pos6_ff};
   assign rsp_tuser  = err6_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata == 96'd0))
      else $error("result with configuration error carries nonzero data");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire
